// ===== rtl/fxa_pkg.sv =====
// shared types, op codes and widths for the fixed-point alu
`default_nettype none
package fxa_pkg;
	localparam int FRAC_BITS = 8;
	localparam int DW        = 32;
	localparam int NUM_W     = DW + FRAC_BITS;
	localparam int QW        = NUM_W;

	typedef enum logic [3:0] {
		OP_ADD     = 4'd0,
		OP_SUB     = 4'd1,
		OP_MUL     = 4'd2,
		OP_DIV     = 4'd3,
		OP_MIN     = 4'd4,
		OP_MAX     = 4'd5,
		OP_INC     = 4'd6,
		OP_DEC     = 4'd7,
		OP_TOINT   = 4'd8,
		OP_FROMINT = 4'd9
	} op_t;

	// what travels down the row alongside the division
	typedef struct packed {
		logic               vld;
		logic               is_div;
		logic               neg;
		logic               dz;
		logic [DW-1:0]      res;
		logic               lt;
		logic               eq;
		logic               gt;
		logic [NUM_W-1:0]   num;
		logic [DW-1:0]      den;
		logic [DW:0]        rem;
		logic [QW-1:0]      quo;
	} cell_t;
endpackage
`default_nettype wire

// ===== rtl/fxa_front.sv =====
// decode stage: simple ops, comparisons, multiplier, and divider operand prep
`default_nettype none
module fxa_front
	import fxa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire logic [3:0]        op,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	output cell_t                  cell_o
);
	logic signed [63:0] prod;
	logic signed [63:0] prod_sh;
	logic [DW-1:0]      r;
	logic               lt, eq, gt;
	logic [DW-1:0]      ma, mb;
	cell_t              c;

	assign lt = operand_a < operand_b;
	assign eq = operand_a == operand_b;
	assign gt = operand_a > operand_b;
	assign prod = 64'(operand_a) * 64'(operand_b);
	assign prod_sh = prod >>> FRAC_BITS;
	assign ma = operand_a[DW-1] ? DW'(-operand_a) : operand_a;
	assign mb = operand_b[DW-1] ? DW'(-operand_b) : operand_b;

	always_comb begin
		case (op)
			OP_ADD:     r = operand_a + operand_b;
			OP_SUB:     r = operand_a - operand_b;
			OP_MUL:     r = prod_sh[DW-1:0];
			OP_MIN:     r = (operand_a <= operand_b) ? operand_a : operand_b;
			OP_MAX:     r = (operand_a >= operand_b) ? operand_a : operand_b;
			OP_INC:     r = operand_a + 32'sd1;
			OP_DEC:     r = operand_a - 32'sd1;
			OP_TOINT:   r = operand_a >>> FRAC_BITS;
			OP_FROMINT: r = operand_a << FRAC_BITS;
			default:    r = '0;
		endcase
	end

	always_comb begin
		c        = '0;
		c.vld    = in_vld;
		c.is_div = (op == OP_DIV) && (operand_b != 32'sd0);
		c.dz     = (op == OP_DIV) && (operand_b == 32'sd0);
		c.neg    = operand_a[DW-1] ^ operand_b[DW-1];
		c.res    = r;
		c.lt     = lt;
		c.eq     = eq;
		c.gt     = gt;
		c.num    = {ma, {FRAC_BITS{1'b0}}};
		c.den    = mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_o <= '0;
		end else if (en) begin
			cell_o <= c;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fxa_cell.sv =====
// one restoring division cell: brings down one dividend bit, makes one quotient bit
`default_nettype none
module fxa_cell
	import fxa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire cell_t cell_i,
	output cell_t      cell_o
);
	logic [DW+1:0] trial;
	logic [DW:0]   shifted;
	cell_t         c;

	assign shifted = {cell_i.rem[DW-1:0], cell_i.num[NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, cell_i.den};

	always_comb begin
		c     = cell_i;
		c.num = {cell_i.num[NUM_W-2:0], 1'b0};
		if (!trial[DW+1]) begin
			c.rem = trial[DW:0];
			c.quo = {cell_i.quo[QW-2:0], 1'b1};
		end else begin
			c.rem = shifted;
			c.quo = {cell_i.quo[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_o <= '0;
		end else if (en) begin
			cell_o <= c;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fixed_point_alu.sv =====
// fixed-point alu top level: decode stage, row of divider cells, output register
//
// Usage: one input channel (in_valid/in_stall with op, operand_a, operand_b)
// and one output channel (out_valid/out_stall with result, compare flags and
// divide_by_zero). Every op, divide or not, travels the same pipeline so
// results leave in order.
// Pipeline: one decode stage holding the multiplier and simple ops, one cell
// per dividend bit of the restoring divider (32 + FRAC_BITS cells), and one
// output register.
// Throughput: one item per cycle unless the output stalls. The whole row
// advances whenever the output register is empty or being taken, so in_stall
// follows out_stall through that single condition; a stalled output freezes
// every stage and the pending beat holds steady.
// Reset: arst_n clears all valid flags; the pipeline comes up empty.
// Division by zero returns 0 with divide_by_zero set.
`default_nettype none
module fixed_point_alu
	import fxa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         op,
	input  wire logic signed [31:0] operand_a,
	input  wire logic signed [31:0] operand_b,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      result,
	output logic                    a_less,
	output logic                    a_equal,
	output logic                    a_greater,
	output logic                    divide_by_zero
);
	cell_t         row [0:NUM_W];
	logic          en;
	logic [DW-1:0] q;
	logic [DW-1:0] fin;

	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	fxa_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in_valid),
		.op(op), .operand_a(operand_a), .operand_b(operand_b), .cell_o(row[0])
	);

	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		fxa_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .cell_i(row[i]), .cell_o(row[i+1])
		);
	end

	assign q = row[NUM_W].quo[DW-1:0];

	always_comb begin
		if (row[NUM_W].dz)          fin = '0;
		else if (row[NUM_W].is_div) fin = row[NUM_W].neg ? DW'(-q) : q;
		else                        fin = row[NUM_W].res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= row[NUM_W].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result         <= fin;
			a_less         <= row[NUM_W].lt;
			a_equal        <= row[NUM_W].eq;
			a_greater      <= row[NUM_W].gt;
			divide_by_zero <= row[NUM_W].dz;
		end
	end
endmodule
`default_nettype wire
